[src/scsd_pkg.sv]
// Shared types and constants of the sync/command to SPI decoder.
// Used by the front, back, top level and checker; depends on nothing.
package scsd_pkg;

	localparam int SYNC_BIT      = 7;
	localparam int CHUNK_BITS    = 7;
	localparam int PAYLOAD_BYTES = 5;
	localparam int PAY_CNT_BITS  = 3;
	localparam logic [PAY_CNT_BITS-1:0] PAY_LAST = PAY_CNT_BITS'(PAYLOAD_BYTES - 1);

	localparam logic [CHUNK_BITS-1:0] CMD_SET_SELECT = 7'h01;
	localparam logic [CHUNK_BITS-1:0] CMD_SET_DATA   = 7'h02;
	localparam logic [CHUNK_BITS-1:0] CMD_ISSUE      = 7'h03;

	typedef enum logic [2:0] {
		PH_SYNC    = 3'b001,
		PH_CMD     = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	localparam int OP_BITS = 3;
	typedef enum logic [OP_BITS-1:0] {
		OP_NONE,
		OP_ISSUE,
		OP_UNKNOWN,
		OP_RESYNC,
		OP_SET_SELECT,
		OP_SET_DATA
	} op_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_ISSUED  = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_RESYNC  = 2'd3
	} status_t;

endpackage

[src/scsd_byte_if.sv]
// Input channel of the decoder: one received byte per transfer.
// Depends on nothing.
interface scsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

[src/scsd_result_if.sv]
// Output channel of the decoder: one status result per transfer.
// Depends on nothing.
interface scsd_result_if #(
	parameter int WORD_BITS    = 32,
	parameter int SELECT_LINES = 4
);
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic [WORD_BITS-1:0]    spi_word;
	logic [SELECT_LINES-1:0] select_mask;

	modport source (output valid, output status, output spi_word, output select_mask,
		input ready);
	modport sink (input valid, input status, input spi_word, input select_mask,
		output ready);
endinterface

[src/sync_command_to_spi_decoder.sv]
// Top level of the sync/command to SPI decoder.
// Depends on scsd_pkg, scsd_byte_if, scsd_result_if, scsd_front, scsd_queue, scsd_back.
//
// Usage: received bytes enter on in_ch, one per transfer. A byte with bit 7 set
// is a sync; command 1 or 2 is followed by five 7-bit payload bytes that load the
// select mask or the SPI word; command 3 issues the stored word with the mask.
// Every accepted byte yields exactly one result on out_ch: status 0 for nothing,
// 1 for an issued word, 2 for an unknown command, 3 for a sync that cut off an
// open transaction. spi_word and select_mask are zero unless status is 1.
// An accepted byte passes into the queue, then into the output register of the
// back end that drives out_ch. Throughput is one byte per cycle while out_ch is
// not stalled, set by the combinational front-end parse and the back's register.
// A two-entry queue separates parsing from execution; when the receiver stalls
// out_ch, the queue fills and in_ch.ready drops only once it is full.
// Reset clears the parser to waiting for sync and zeroes the stored SPI word
// and select mask; no results are pending after reset.
module sync_command_to_spi_decoder #(
	parameter int WORD_BITS    = 32,
	parameter int SELECT_LINES = 4
) (
	input logic           clk,
	input logic           arst_n,
	scsd_byte_if.sink     in_ch,
	scsd_result_if.source out_ch
);

	localparam int QW = scsd_pkg::OP_BITS + WORD_BITS;

	logic                 push, push_ready, pop_valid, pop;
	scsd_pkg::op_t        push_op;
	logic [WORD_BITS-1:0] push_word;
	logic [QW-1:0]        pop_data;

	scsd_front #(.WORD_BITS(WORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.rx_byte    (in_ch.rx_byte),
		.push       (push),
		.push_ready (push_ready),
		.push_op    (push_op),
		.push_word  (push_word)
	);

	scsd_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  ({push_op, push_word}),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	scsd_back #(.WORD_BITS(WORD_BITS), .SELECT_LINES(SELECT_LINES)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (pop_valid),
		.op_pop      (pop),
		.op          (scsd_pkg::op_t'(pop_data[QW-1:WORD_BITS])),
		.op_word     (pop_data[WORD_BITS-1:0]),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.status      (out_ch.status),
		.spi_word    (out_ch.spi_word),
		.select_mask (out_ch.select_mask)
	);

endmodule

[src/scsd_front.sv]
// Front end: parses received bytes and turns each into one queued operation.
// Depends on scsd_pkg.
module scsd_front #(
	parameter int WORD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                rx_byte,
	output logic                      push,
	input  logic                      push_ready,
	output scsd_pkg::op_t             push_op,
	output logic [WORD_BITS-1:0]      push_word
);

	scsd_pkg::phase_t                      phase_q, phase_d;
	logic                                  target_q, target_d;
	logic [scsd_pkg::PAY_CNT_BITS-1:0]     cnt_q, cnt_d;
	logic [WORD_BITS-1:0]                  asm_q, asm_d;
	logic [scsd_pkg::CHUNK_BITS-1:0]       chunk;
	logic                                  accept;

	assign chunk    = rx_byte[scsd_pkg::CHUNK_BITS-1:0];
	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;
	assign push     = accept;
	assign push_word = asm_d;

	always_comb begin
		phase_d  = phase_q;
		target_d = target_q;
		cnt_d    = cnt_q;
		asm_d    = asm_q;
		push_op  = scsd_pkg::OP_NONE;
		if (rx_byte[scsd_pkg::SYNC_BIT]) begin
			if (phase_q != scsd_pkg::PH_SYNC) begin
				push_op = scsd_pkg::OP_RESYNC;
			end
			phase_d = scsd_pkg::PH_CMD;
		end else begin
			case (phase_q)
				scsd_pkg::PH_CMD: begin
					case (chunk) inside
						scsd_pkg::CMD_SET_SELECT, scsd_pkg::CMD_SET_DATA: begin
							target_d = (chunk == scsd_pkg::CMD_SET_DATA);
							cnt_d    = '0;
							phase_d  = scsd_pkg::PH_PAYLOAD;
						end
						scsd_pkg::CMD_ISSUE: begin
							push_op = scsd_pkg::OP_ISSUE;
							phase_d = scsd_pkg::PH_SYNC;
						end
						default: begin
							push_op = scsd_pkg::OP_UNKNOWN;
							phase_d = scsd_pkg::PH_SYNC;
						end
					endcase
				end
				scsd_pkg::PH_PAYLOAD: begin
					if (cnt_q == '0) begin
						asm_d = {{(WORD_BITS-scsd_pkg::CHUNK_BITS){1'b0}}, chunk};
					end else begin
						asm_d = {asm_q[WORD_BITS-scsd_pkg::CHUNK_BITS-1:0], chunk};
					end
					if (cnt_q == scsd_pkg::PAY_LAST) begin
						push_op = target_q ? scsd_pkg::OP_SET_DATA : scsd_pkg::OP_SET_SELECT;
						phase_d = scsd_pkg::PH_SYNC;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= scsd_pkg::PH_SYNC;
			target_q <= 1'b0;
			cnt_q    <= '0;
			asm_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			target_q <= target_d;
			cnt_q    <= cnt_d;
			asm_q    <= asm_d;
		end
	end

endmodule

[src/scsd_queue.sv]
// Small first-in first-out queue between the front end and the back end.
// Depends on nothing.
module scsd_queue #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/scsd_back.sv]
// Back end: carries out queued operations, holds the select mask and SPI word,
// and drives the registered result. Depends on scsd_pkg.
module scsd_back #(
	parameter int WORD_BITS    = 32,
	parameter int SELECT_LINES = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    op_valid,
	output logic                    op_pop,
	input  scsd_pkg::op_t           op,
	input  logic [WORD_BITS-1:0]    op_word,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              status,
	output logic [WORD_BITS-1:0]    spi_word,
	output logic [SELECT_LINES-1:0] select_mask
);

	logic                    valid_q;
	scsd_pkg::status_t       status_q;
	logic [WORD_BITS-1:0]    word_q;
	logic [SELECT_LINES-1:0] mask_q;
	logic [SELECT_LINES-1:0] cs_q;
	logic [WORD_BITS-1:0]    data_q;

	assign op_pop      = op_valid && (!valid_q || out_ready);
	assign out_valid   = valid_q;
	assign status      = status_q;
	assign spi_word    = word_q;
	assign select_mask = mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			status_q <= scsd_pkg::ST_NONE;
			word_q   <= '0;
			mask_q   <= '0;
			cs_q     <= '0;
			data_q   <= '0;
		end else begin
			if (op_pop) begin
				valid_q  <= 1'b1;
				status_q <= scsd_pkg::ST_NONE;
				word_q   <= '0;
				mask_q   <= '0;
				case (op)
					scsd_pkg::OP_ISSUE: begin
						status_q <= scsd_pkg::ST_ISSUED;
						word_q   <= data_q;
						mask_q   <= cs_q;
					end
					scsd_pkg::OP_UNKNOWN: status_q <= scsd_pkg::ST_UNKNOWN;
					scsd_pkg::OP_RESYNC:  status_q <= scsd_pkg::ST_RESYNC;
					scsd_pkg::OP_SET_SELECT: cs_q <= op_word[SELECT_LINES-1:0];
					scsd_pkg::OP_SET_DATA:   data_q <= op_word;
					default: begin
					end
				endcase
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/scsd_checker.sv]
// Port-level assertions for the sync/command to SPI decoder, with their bind.
// Depends on scsd_pkg and sync_command_to_spi_decoder.
module scsd_assertions #(
	parameter int WORD_BITS    = 32,
	parameter int SELECT_LINES = 4
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [1:0]              status,
	input logic [WORD_BITS-1:0]    spi_word,
	input logic [SELECT_LINES-1:0] select_mask
);

	// A stalled result must hold until the receiver takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(spi_word)
			&& $stable(select_mask))
		else $error("result changed or vanished while stalled");

	// Only an issued word carries a word and a mask.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != scsd_pkg::ST_ISSUED |-> spi_word == '0 && select_mask == '0)
		else $error("nonzero word or mask on a result that issued nothing");

	// Input back-pressure only appears after the output was backed up.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && $past(!out_ready))
		else $error("input stalled while the output was free");

	// An accepted byte always leads to a pending result.
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("accepted byte produced no result");

endmodule

bind sync_command_to_spi_decoder scsd_assertions #(
	.WORD_BITS    (WORD_BITS),
	.SELECT_LINES (SELECT_LINES)
) u_scsd_assertions (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.status      (out_ch.status),
	.spi_word    (out_ch.spi_word),
	.select_mask (out_ch.select_mask)
);
